@@ hdl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Result record and status codes shared by the decoder core.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

   localparam int unsigned CpWidth  = 21;
   localparam int unsigned LenWidth = 3;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_STRAY     = 3'd1,
      ST_OVERSIZE  = 3'd2,
      ST_INTERRUPT = 3'd3,
      ST_TRUNCATED = 3'd4,
      ST_OVERLONG  = 3'd5
   } status_type;

   // One result; the low 27 bits line up with the packed rsp_tdata layout
   typedef struct packed {
      logic                  final_result;
      status_type            status;
      logic [LenWidth-1:0]   seq_length;
      logic [CpWidth-1:0]    code_point;
   } rsp_type;

   localparam logic [CpWidth-1:0] MinTwo   = 21'h00080;
   localparam logic [CpWidth-1:0] MinThree = 21'h00800;
   localparam logic [CpWidth-1:0] MinFour  = 21'h10000;

endpackage

`default_nettype wire

@@ hdl/utf8_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Decodes a byte stream into code points with per-character error status.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per transfer; req_tlast marks the last byte
//   of the text. rsp_* carries decoded results; rsp_tlast marks the last
//   result caused by the end-of-text byte. A byte gives zero, one or two
//   results (an interrupted sequence plus the decode of the interrupting
//   byte; at end of text that decode may be the truncation of the sequence it opens).
//   csr_wen/csr_wdata set the longest accepted sequence length; write it
//   only while the block is idle.
// Timing:
//   A byte is registered in the input stage, decoded combinationally into a
//   three-entry result queue, and shown on rsp_* from that queue. One byte
//   per cycle is sustained while the receiver takes every result and each
//   byte gives at most one result; a byte with two results holds the input
//   stream while the single result port drains the queue.
// Reset:
//   Clears the queue, the input stage and the sequence state; the length
//   limit returns to 4. When the receiver stalls, results collect in the
//   queue and req_tready drops once the queue could not hold two more.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // config
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_wdata,    // max_seq_len
   // byte stream in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] text_byte
   input  wire logic        req_tlast,    // end_of_text
   // result stream out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [20:0] code_point, [23:21] seq_length,
                                          // [26:24] status, [31:27] zero
   output logic             rsp_tlast     // final_result
);

   localparam int unsigned QDepth = 3;

   // configuration
   logic [2:0] max_len_ff;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   // sequence state
   logic        in_seq_ff,  in_seq_in;
   logic [2:0]  exp_len_ff, exp_len_in;
   logic [1:0]  remain_ff,  remain_in;
   logic [20:0] acc_ff,     acc_in;

   // result queue
   utf8d_pkg::rsp_type q_mem_ff [QDepth];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff,  count_in;

   logic       room;
   logic       decode_fire;
   logic       pop;

   // decode signals
   logic [2:0] eff_max;
   logic       raw_mode;
   logic [3:0] lead_ones;
   logic [2:0] lead_len;
   logic       lead_emit;
   utf8d_pkg::rsp_type lead_res;
   logic       is_cont;
   logic       interrupt;
   logic       use_lead;
   logic       cont_step;
   logic [20:0] cont_acc;
   logic [1:0]  cont_remain;
   logic [20:0] min_val;
   utf8d_pkg::rsp_type res [2];
   logic [1:0] push_n;
   logic [1:0] wr_ptr_p1;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign room        = (count_ff <= 2'd1);
   assign decode_fire = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || room;
   assign rsp_tvalid  = (count_ff != 2'd0);
   assign pop         = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 3'd4;
      end else if (csr_wen) begin
         max_len_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (decode_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   // ---------------------------------------------------------------------
   // lead byte decode
   // ---------------------------------------------------------------------
   always_comb begin
      case (max_len_ff) inside
         3'd0:             eff_max = 3'd1;
         3'd5, 3'd6, 3'd7: eff_max = 3'd4;
         default:          eff_max = max_len_ff;
      endcase
   end

   assign raw_mode = (eff_max == 3'd1);

   always_comb begin
      unique casez (in_byte_ff)
         8'b0???????: lead_ones = 4'd0;
         8'b10??????: lead_ones = 4'd1;
         8'b110?????: lead_ones = 4'd2;
         8'b1110????: lead_ones = 4'd3;
         8'b11110???: lead_ones = 4'd4;
         8'b111110??: lead_ones = 4'd5;
         8'b1111110?: lead_ones = 4'd6;
         8'b11111110: lead_ones = 4'd7;
         default:     lead_ones = 4'd8;
      endcase
   end

   assign lead_len = (lead_ones > 4'd7) ? 3'd7 : lead_ones[2:0];
   assign is_cont  = (in_byte_ff[7:6] == 2'b10);

   always_comb begin
      lead_emit = 1'b1;
      lead_res  = '{final_result: 1'b0, status: utf8d_pkg::ST_OK,
                    seq_length: 3'd1, code_point: '0};
      if (lead_ones == 4'd0) begin
         lead_res.code_point = {13'd0, in_byte_ff};
      end else if (lead_ones == 4'd1) begin
         lead_res.status = utf8d_pkg::ST_STRAY;
      end else if (lead_ones > {1'b0, eff_max}) begin
         lead_res.status     = utf8d_pkg::ST_OVERSIZE;
         lead_res.seq_length = lead_len;
      end else begin
         lead_emit = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // step: results and next sequence state
   // ---------------------------------------------------------------------
   assign interrupt = in_seq_ff && (raw_mode || !is_cont);
   assign use_lead  = !raw_mode && (!in_seq_ff || !is_cont);
   assign cont_step = !raw_mode && in_seq_ff && is_cont;

   assign cont_acc    = {acc_ff[14:0], in_byte_ff[5:0]};
   assign cont_remain = remain_ff - 2'd1;

   always_comb begin
      case (exp_len_ff)
         3'd2:    min_val = utf8d_pkg::MinTwo;
         3'd3:    min_val = utf8d_pkg::MinThree;
         default: min_val = utf8d_pkg::MinFour;
      endcase
   end

   always_comb begin
      res[0]     = '{final_result: 1'b0, status: utf8d_pkg::ST_OK,
                     seq_length: '0, code_point: '0};
      res[1]     = res[0];
      push_n     = 2'd0;
      in_seq_in  = in_seq_ff;
      exp_len_in = exp_len_ff;
      remain_in  = remain_ff;
      acc_in     = acc_ff;

      if (interrupt) begin
         res[0].status     = utf8d_pkg::ST_INTERRUPT;
         res[0].seq_length = exp_len_ff;
         push_n            = 2'd1;
         in_seq_in         = 1'b0;
         exp_len_in        = '0;
         remain_in         = '0;
         acc_in            = '0;
      end

      if (raw_mode) begin
         res[push_n[0]].code_point = {13'd0, in_byte_ff};
         res[push_n[0]].seq_length = 3'd1;
         push_n                    = push_n + 2'd1;
      end

      if (use_lead) begin
         if (lead_emit) begin
            res[push_n[0]] = lead_res;
            push_n         = push_n + 2'd1;
         end else begin
            in_seq_in  = 1'b1;
            exp_len_in = lead_ones[2:0];
            remain_in  = lead_ones[1:0] - 2'd1;
            acc_in     = {13'd0, in_byte_ff & (8'h7F >> lead_ones)};
         end
      end

      if (cont_step) begin
         acc_in    = cont_acc;
         remain_in = cont_remain;
         if (cont_remain == 2'd0) begin
            res[push_n[0]].seq_length = exp_len_ff;
            if (cont_acc < min_val) begin
               res[push_n[0]].status = utf8d_pkg::ST_OVERLONG;
            end else begin
               res[push_n[0]].code_point = cont_acc;
            end
            push_n     = push_n + 2'd1;
            in_seq_in  = 1'b0;
            exp_len_in = '0;
            remain_in  = '0;
            acc_in     = '0;
         end
      end

      if (in_eot_ff) begin
         if (in_seq_in) begin
            res[push_n[0]].status     = utf8d_pkg::ST_TRUNCATED;
            res[push_n[0]].seq_length = exp_len_in;
            push_n                    = push_n + 2'd1;
         end
         in_seq_in  = 1'b0;
         exp_len_in = '0;
         remain_in  = '0;
         acc_in     = '0;
         // tag the last result of this byte
         if (push_n != 2'd0) begin
            res[push_n[1]].final_result = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_seq_ff  <= 1'b0;
         exp_len_ff <= '0;
         remain_ff  <= '0;
         acc_ff     <= '0;
      end else if (decode_fire) begin
         in_seq_ff  <= in_seq_in;
         exp_len_ff <= exp_len_in;
         remain_ff  <= remain_in;
         acc_ff     <= acc_in;
      end
   end

   // ---------------------------------------------------------------------
   // result queue
   // ---------------------------------------------------------------------
   assign wr_ptr_p1 = (wr_ptr_ff == 2'(QDepth - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'(QDepth - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (decode_fire) begin
         if (push_n == 2'd1) begin
            wr_ptr_in = wr_ptr_p1;
         end else if (push_n == 2'd2) begin
            wr_ptr_in = (wr_ptr_p1 == 2'(QDepth - 1)) ? 2'd0 : wr_ptr_p1 + 2'd1;
         end
         count_in = count_ff + push_n - {1'b0, pop};
      end else begin
         count_in = count_ff - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (decode_fire && (push_n != 2'd0)) begin
         q_mem_ff[wr_ptr_ff] <= res[0];
      end
      if (decode_fire && (push_n == 2'd2)) begin
         q_mem_ff[wr_ptr_p1] <= res[1];
      end
   end

   assign rsp_tdata = {5'd0, q_mem_ff[rd_ptr_ff].status,
                       q_mem_ff[rd_ptr_ff].seq_length,
                       q_mem_ff[rd_ptr_ff].code_point};
   assign rsp_tlast = q_mem_ff[rd_ptr_ff].final_result;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_seq_state_sane: assert property (@(posedge clock) disable iff (reset)
      in_seq_ff |-> (exp_len_ff >= 3'd2 && exp_len_ff <= 3'd4 && remain_ff != 2'd0 &&
                     {1'b0, remain_ff} < exp_len_ff))
      else $error("pending sequence state is inconsistent");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      decode_fire && in_eot_ff |=> !in_seq_ff && acc_ff == '0)
      else $error("sequence state survives end of text");

   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      decode_fire && in_eot_ff |-> push_n != 2'd0)
      else $error("end-of-text byte produced no result");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      decode_fire |-> ({1'b0, count_ff} + {1'b0, push_n}) <= 3'(QDepth))
      else $error("result queue overflow");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core testbench
// Streams directed and random UTF-8 text through the core under several
// length limits. A behavioral decoder predicts every result, and each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_wdata = 3'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   // Behavioral decoder state
   logic [2:0]  limit_reg = 3'd4;
   logic        seq_open = 1'b0;
   logic [2:0]  seq_len = 3'd0;
   logic [1:0]  seq_left = 2'd0;
   logic [20:0] seq_value = 21'd0;

   utf8d_pkg::rsp_type byte_results[$];
   utf8d_pkg::rsp_type expected_decodes[$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int error_count = 0;
   int results_checked = 0;
   int bytes_sent = 0;
   int texts_sent = 0;
   int limit_writes = 0;
   int status_seen[6] = '{default: 0};

   utf8_stream_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Behavioral decoder
   // ------------------------------------------------------------------------
   function automatic int active_limit();
      if (limit_reg == 3'd0) return 1;
      if (limit_reg > 3'd4) return 4;
      return int'(limit_reg);
   endfunction

   function automatic void add_result(logic [20:0] cp, logic [2:0] len,
                                      utf8d_pkg::status_type st);
      utf8d_pkg::rsp_type r;
      r.final_result = 1'b0;
      r.status       = st;
      r.seq_length   = len;
      r.code_point   = cp;
      byte_results.push_back(r);
   endfunction

   function automatic void clear_sequence();
      seq_open  = 1'b0;
      seq_len   = 3'd0;
      seq_left  = 2'd0;
      seq_value = 21'd0;
   endfunction

   function automatic void decode_lead(logic [7:0] b);
      int ones;
      ones = 0;
      while (ones < 8 && b[7 - ones]) ones++;
      if (ones == 0) begin
         add_result({13'd0, b}, 3'd1, utf8d_pkg::ST_OK);
      end else if (ones == 1) begin
         add_result(21'd0, 3'd1, utf8d_pkg::ST_STRAY);
      end else if (ones > active_limit()) begin
         add_result(21'd0, (ones > 7) ? 3'd7 : 3'(ones), utf8d_pkg::ST_OVERSIZE);
      end else begin
         seq_open  = 1'b1;
         seq_len   = 3'(ones);
         seq_left  = 2'(ones - 1);
         seq_value = 21'(b & (8'h7F >> ones));
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eot);
      logic [20:0] min_value;
      byte_results.delete();
      if (active_limit() <= 1) begin
         // raw mode: close any pending sequence first
         if (seq_open) begin
            add_result(21'd0, seq_len, utf8d_pkg::ST_INTERRUPT);
            clear_sequence();
         end
         add_result({13'd0, b}, 3'd1, utf8d_pkg::ST_OK);
      end else if (seq_open) begin
         if (b[7:6] == 2'b10) begin
            seq_value = {seq_value[14:0], b[5:0]};
            seq_left  = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
               min_value = (seq_len == 3'd2) ? utf8d_pkg::MinTwo :
                           (seq_len == 3'd3) ? utf8d_pkg::MinThree : utf8d_pkg::MinFour;
               if (seq_value < min_value)
                  add_result(21'd0, seq_len, utf8d_pkg::ST_OVERLONG);
               else
                  add_result(seq_value, seq_len, utf8d_pkg::ST_OK);
               clear_sequence();
            end
         end else begin
            // interrupting byte starts over as a new lead
            add_result(21'd0, seq_len, utf8d_pkg::ST_INTERRUPT);
            clear_sequence();
            decode_lead(b);
         end
      end else begin
         decode_lead(b);
      end
      if (eot) begin
         if (seq_open) begin
            add_result(21'd0, seq_len, utf8d_pkg::ST_TRUNCATED);
            clear_sequence();
         end
         if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].final_result = 1'b1;
      end
      foreach (byte_results[k]) begin
         status_seen[int'(byte_results[k].status)]++;
         expected_decodes.push_back(byte_results[k]);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers; all are entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] text_byte, input logic end_of_text);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = text_byte;
      req_tlast  = end_of_text;
      do @(posedge clock); while (!req_tready);
      // predict after the edge so the checker never races the push
      @(negedge clock);
      decode_byte(text_byte, end_of_text);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (expected_decodes.size() != 0) @(negedge clock);
      // a byte with no result may still be in the pipeline
      repeat (6) @(negedge clock);
   endtask

   task automatic write_max_len(input logic [2:0] value);
      csr_wen   = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_wen   = 1'b0;
      limit_reg = value;
      limit_writes++;
   endtask

   function automatic logic [2:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return 3'd1;
         1:       return 3'd0;
         2:       return 3'($urandom_range(7, 5));
         3, 4:    return 3'($urandom_range(3, 2));
         default: return 3'd4;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_decode();
      // {end_of_text, byte}
      logic [8:0] script[20] = '{
         9'h141,                          // ASCII alone, end of text
         9'h000,                          // lowest byte
         9'h0C3, 9'h0A9,                  // two-byte character
         9'h0E2, 9'h082, 9'h0AC,          // three-byte character
         9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte character
         9'h080,                          // stray continuation
         9'h0F8,                          // lead too long for the limit
         9'h0FF,                          // all ones, length capped
         9'h0C0, 9'h080,                  // overlong two-byte form
         9'h0C3, 9'h1E2,                  // interrupted, then cut off at end
         9'h0E2, 9'h182                   // cut off at end
      };
      foreach (script[k]) send_byte(script[k][7:0], script[k][8]);
      drain_results();
   endtask

   task automatic test_limit_changes();
      write_max_len(3'd4);
      // lower the limit with a three-byte sequence pending
      send_byte(8'hE2, 1'b0);
      drain_results();
      write_max_len(3'd2);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hE2, 1'b0);
      // switch to raw with a sequence pending
      send_byte(8'hC3, 1'b0);
      drain_results();
      write_max_len(3'd0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hFF, 1'b0);
      drain_results();
      write_max_len(3'd7);
      send_byte(8'hF8, 1'b1);
      drain_results();
   endtask

   task automatic test_random_text(input int tx_pct, input int rx_pct, input int byte_budget);
      int          sent;
      int          n_chars;
      int          kind;
      int          len;
      int          keep;
      int          split_at;
      int          lo;
      int          hi;
      logic [20:0] value;
      logic [7:0]  lead;
      logic [7:0]  text[$];
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      sent = 0;
      while (sent < byte_budget) begin
         if ($urandom_range(0, 3) == 0) begin
            drain_results();
            write_max_len(pick_limit());
         end
         text.delete();
         n_chars = $urandom_range(1, 10);
         repeat (n_chars) begin
            kind = $urandom_range(0, 19);
            if (kind == 19) begin
               text.push_back(8'($urandom_range(255, 0)));
            end else begin
               len = $urandom_range(1, 4);
               case (len)
                  1:       begin lo = 0;       hi = 'h7F;     end
                  2:       begin lo = 'h80;    hi = 'h7FF;    end
                  3:       begin lo = 'h800;   hi = 'hFFFF;   end
                  default: begin lo = 'h10000; hi = 'h1FFFFF; end
               endcase
               // overlong: a value that fits a shorter form
               if (kind == 16 && len > 1) begin
                  hi = lo - 1;
                  lo = 0;
               end
               value = 21'($urandom_range(hi, lo));
               case (len)
                  1:       lead = 8'(value);
                  2:       lead = 8'hC0 | 8'(value >> 6);
                  3:       lead = 8'hE0 | 8'(value >> 12);
                  default: lead = 8'hF0 | 8'(value >> 18);
               endcase
               // cut short: drop trailing continuations
               keep = (kind >= 17 && len > 1) ? $urandom_range(len - 1, 1) : len;
               text.push_back(lead);
               for (int k = 1; k < keep; k++)
                  text.push_back(8'h80 | (8'(value >> (6 * (len - 1 - k))) & 8'h3F));
            end
         end
         split_at = (text.size() > 1 && $urandom_range(0, 4) == 0) ?
                    $urandom_range(text.size() - 1, 1) : 0;
         foreach (text[i]) begin
            if (split_at != 0 && i == split_at) begin
               // hold the stream mid-text until every result is back
               drain_results();
               write_max_len(pick_limit());
            end
            send_byte(text[i], i == text.size() - 1);
         end
         sent += text.size();
         texts_sent++;
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      utf8d_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_decodes.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h tlast %b",
                   rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_decodes.pop_front();
            if (rsp_tdata[20:0] !== want.code_point) begin
               $error("code_point: expected %h, got %h", want.code_point, rsp_tdata[20:0]);
               error_count++;
            end
            if (rsp_tdata[23:21] !== want.seq_length) begin
               $error("seq_length: expected %0d, got %0d", want.seq_length, rsp_tdata[23:21]);
               error_count++;
            end
            if (rsp_tdata[26:24] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[26:24]);
               error_count++;
            end
            if (rsp_tlast !== want.final_result) begin
               $error("final_result: expected %b, got %b", want.final_result, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[31:27] !== 5'd0) begin
               $error("tdata padding: expected 0, got %h", rsp_tdata[31:27]);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      tx_idle_pct = 22;
      rx_idle_pct = 62;
      test_directed_decode();
      test_limit_changes();
      test_random_text(22, 62, 517);
      test_random_text(62, 22, 517);
      test_random_text(0, 0, 516);
      repeat (10) @(negedge clock);
      $display("Sent %0d bytes (%0d random texts) under %0d limit writes;",
               bytes_sent, texts_sent, limit_writes);
      $display("%0d results checked: ok %0d, stray %0d, oversize %0d, interrupted %0d,",
               results_checked, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      $display("truncated %0d, overlong %0d", status_seen[4], status_seen[5]);
      if (error_count == 0) begin
         $display("** utf8_stream_decoder_core: PASSED **");
      end else begin
         $display("** utf8_stream_decoder_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", expected_decodes.size());
      $display("** utf8_stream_decoder_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
